/* rtl/core/hrhc_pkg.sv */
// Shared types and constants for the HTTP response header checker.
package hrhc_pkg;

  // Parse phases
  localparam logic [3:0] PH_SEEK   = 4'd0;
  localparam logic [3:0] PH_VER    = 4'd1;
  localparam logic [3:0] PH_STATUS = 4'd2;
  localparam logic [3:0] PH_REASON = 4'd3;
  localparam logic [3:0] PH_KEY    = 4'd4;
  localparam logic [3:0] PH_VALUE  = 4'd5;

  // Error codes
  localparam logic [3:0] ERR_OK         = 4'd0;
  localparam logic [3:0] ERR_VERSION    = 4'd1;
  localparam logic [3:0] ERR_STATUS_BAD = 4'd2;
  localparam logic [3:0] ERR_STATUS_UNK = 4'd3;
  localparam logic [3:0] ERR_NO_SEP     = 4'd4;
  localparam logic [3:0] ERR_NO_NAME    = 4'd5;
  localparam logic [3:0] ERR_NO_VALUE   = 4'd6;
  localparam logic [3:0] ERR_BAD_CHAR   = 4'd7;
  localparam logic [3:0] ERR_TOO_BIG    = 4'd8;

  // Line flag bits
  localparam logic [3:0] LF_KEY_SEEN = 4'b0001;
  localparam logic [3:0] LF_KEY_BAD  = 4'b0010;
  localparam logic [3:0] LF_VAL_SEEN = 4'b0100;
  localparam logic [3:0] LF_VAL_BAD  = 4'b1000;

  // Pending mark bits
  localparam logic [1:0] PM_CR    = 2'b01;
  localparam logic [1:0] PM_COLON = 2'b10;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [15:0] MAX_BYTES_RESET = 16'd10240;
  localparam logic [15:0] BYTES_SAT       = 16'hFFFF;
  localparam logic [9:0]  HEADERS_SAT     = 10'd1023;

  typedef struct packed {
    logic name_safe;
    logic value_safe;
  } char_class_t;

  typedef struct packed {
    logic [3:0]  error_code;
    logic        version_minor;
    logic [9:0]  resp_code;
    logic [9:0]  header_count;
    logic [15:0] header_bytes;
  } hrhc_result_t;

endpackage

/* rtl/core/http_response_header_checker.sv */
// HTTP response header checker: streaming status line and header validation.
//
// The block takes one response byte per input word and checks the HTTP
// response head as it streams past: it skips to the first '/', requires
// version 1.0 or 1.1, a three-digit known status code followed by a space,
// and then "key: value" lines up to the empty line (CRLFCRLF). For each
// response it returns at most one output word, either at the first error or
// at the CRLFCRLF, carrying the error code, version, status code, number of
// header lines accepted and bytes consumed. After that word it ignores bytes
// until one arrives with first_byte set, which starts a new response. Bytes
// beyond max_header_bytes give error 8 (too big).
// Rate: one byte per clock, sustained while the output keeps up. A byte is
// taken into the input register; when it advances, the parse state and
// result are worked out from it, and a result word is loaded into the output
// register, so out_valid rises in the cycle after that byte advances. The
// output register and the input register together let a new byte be taken
// while a result waits; the input only stalls when a result word is held and
// out_ready is low.
// max_header_bytes (cfg_wr_data) resets to 10240 and should only be written
// while no response is in flight.
module http_response_header_checker import hrhc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // input bytes
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  error_code,
  output logic        version_minor,
  output logic [9:0]  resp_code,
  output logic [9:0]  header_count,
  output logic [15:0] header_bytes
);

  logic [15:0]  max_header_bytes;

  // input register
  logic         held_valid, held_valid_next;
  logic [7:0]   held_byte;
  logic         held_first;

  logic         advance;
  logic         res_valid;
  hrhc_result_t result;

  // output register
  logic         out_valid_next;
  hrhc_result_t out_word;

  // The held byte is processed when there is room for a possible result.
  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_header_bytes <= MAX_BYTES_RESET;
    end else if (cfg_wr_en) begin
      max_header_bytes <= cfg_wr_data;
    end
  end

  always_comb begin
    held_valid_next = held_valid;
    if (in_valid && in_ready) begin
      held_valid_next = 1'b1;
    end else if (advance) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte  <= data_byte;
      held_first <= first_byte;
    end
  end

  hrhc_parser u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .data_byte        (held_byte),
    .first_byte       (held_first),
    .max_header_bytes (max_header_bytes),
    .res_valid        (res_valid),
    .result           (result)
  );

  // Result word is loaded when a processed byte ends the response head.
  always_comb begin
    out_valid_next = out_valid;
    if (advance && res_valid) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_word <= result;
    end
  end

  assign error_code    = out_word.error_code;
  assign version_minor = out_word.version_minor;
  assign resp_code     = out_word.resp_code;
  assign header_count  = out_word.header_count;
  assign header_bytes  = out_word.header_bytes;

endmodule

/* rtl/core/hrhc_char_class.sv */
// Character classes for header keys and values.
module hrhc_char_class import hrhc_pkg::*; (
  input  logic [7:0]  data_byte,
  output char_class_t char_class
);

  logic alnum;
  logic symbol;

  assign alnum = (data_byte >= 8'h30 && data_byte <= 8'h39) ||
                 (data_byte >= 8'h61 && data_byte <= 8'h7A) ||
                 (data_byte >= 8'h41 && data_byte <= 8'h5A);

  // Safe punctuation in values
  always_comb begin
    case (data_byte)
      8'h5F, 8'h20, 8'h3A, 8'h3B, 8'h2E, 8'h2C, 8'h5C, 8'h2F, 8'h22, 8'h27,
      8'h3F, 8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h40, 8'h3C,
      8'h3E, 8'h3D, 8'h2D, 8'h2B, 8'h2A, 8'h23, 8'h24, 8'h26, 8'h60, 8'h7C,
      8'h7E, 8'h5E, 8'h25: symbol = 1'b1;
      default: symbol = 1'b0;
    endcase
  end

  assign char_class.name_safe  = alnum || data_byte == 8'h2D || data_byte == 8'h5F;
  assign char_class.value_safe = alnum || symbol;

endmodule

/* rtl/core/hrhc_status_table.sv */
// Table of known HTTP status codes.
module hrhc_status_table import hrhc_pkg::*; (
  input  logic [9:0] code_value,
  output logic       known
);

  always_comb begin
    case (code_value)
      10'd100, 10'd101, 10'd102, 10'd103,
      10'd200, 10'd201, 10'd202, 10'd203, 10'd204, 10'd205, 10'd206, 10'd207,
      10'd208, 10'd226,
      10'd300, 10'd301, 10'd302, 10'd303, 10'd304, 10'd305, 10'd307, 10'd308,
      10'd400, 10'd401, 10'd402, 10'd403, 10'd404, 10'd405, 10'd406, 10'd407,
      10'd408, 10'd409, 10'd410, 10'd411, 10'd412, 10'd413, 10'd414, 10'd415,
      10'd416, 10'd417, 10'd418, 10'd421, 10'd422, 10'd423, 10'd424, 10'd425,
      10'd426, 10'd428, 10'd429, 10'd431, 10'd451,
      10'd500, 10'd501, 10'd502, 10'd503, 10'd504, 10'd505, 10'd506, 10'd507,
      10'd508, 10'd510, 10'd511: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

endmodule

/* rtl/core/hrhc_parser.sv */
// Parse state and per-byte step logic of the header checker.
module hrhc_parser import hrhc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         first_byte,
  input  logic [15:0]  max_header_bytes,
  output logic         res_valid,
  output hrhc_result_t result
);

  logic [3:0]  parse_phase, parse_phase_next;
  logic        finished, finished_next;
  logic [15:0] byte_count, byte_count_next;
  logic [2:0]  field_position, field_position_next;
  logic        version_bit, version_bit_next;
  logic [9:0]  code_value, code_value_next;
  logic [3:0]  line_flags, line_flags_next;
  logic [1:0]  pending_marks, pending_marks_next;
  logic [1:0]  crlf_run, crlf_run_next;
  logic [9:0]  headers_seen, headers_seen_next;

  // state as seen by this byte (first_byte clears it)
  logic [3:0]  ph;
  logic        fin;
  logic [15:0] bc;
  logic [2:0]  fp;
  logic        vb;
  logic [9:0]  cv;
  logic [3:0]  lf;
  logic [1:0]  pm;
  logic [1:0]  run;
  logic [9:0]  hs;

  char_class_t cls;
  logic        code_ok;
  logic [3:0]  err;
  logic        show_status;
  logic [7:0]  mark;

  hrhc_char_class u_class (
    .data_byte  (data_byte),
    .char_class (cls)
  );

  hrhc_status_table u_table (
    .code_value (cv),
    .known      (code_ok)
  );

  always_comb begin
    logic handled;
    logic skip;
    ph  = first_byte ? PH_SEEK : parse_phase;
    fin = first_byte ? 1'b0    : finished;
    bc  = first_byte ? 16'd0   : byte_count;
    fp  = first_byte ? 3'd0    : field_position;
    vb  = first_byte ? 1'b0    : version_bit;
    cv  = first_byte ? 10'd0   : code_value;
    lf  = first_byte ? 4'd0    : line_flags;
    pm  = first_byte ? 2'd0    : pending_marks;
    run = first_byte ? 2'd0    : crlf_run;
    hs  = first_byte ? 10'd0   : headers_seen;

    parse_phase_next    = ph;
    finished_next       = fin;
    byte_count_next     = bc;
    field_position_next = fp;
    version_bit_next    = vb;
    code_value_next     = cv;
    line_flags_next     = lf;
    pending_marks_next  = pm;
    crlf_run_next       = run;
    headers_seen_next   = hs;

    res_valid   = 1'b0;
    err         = ERR_OK;
    show_status = 1'b0;
    handled     = 1'b0;
    skip        = 1'b0;
    mark        = (run[0]) ? CH_LF : CH_CR;

    if (!fin) begin
      if (bc != BYTES_SAT) begin
        byte_count_next = bc + 16'd1;
      end
      if (bc >= max_header_bytes) begin
        res_valid = 1'b1;
        err       = ERR_TOO_BIG;
      end else begin
        case (ph)
          PH_SEEK: begin
            if (data_byte == CH_SLASH) begin
              parse_phase_next    = PH_VER;
              field_position_next = 3'd0;
            end else if (data_byte == mark) begin
              if (run == 2'd3) begin
                res_valid = 1'b1;
                err       = ERR_VERSION;
              end else begin
                crlf_run_next = run + 2'd1;
              end
            end else begin
              crlf_run_next = (data_byte == CH_CR) ? 2'd1 : 2'd0;
            end
          end
          PH_VER: begin
            if (fp == 3'd0 && data_byte == CH_ONE) begin
              field_position_next = 3'd1;
            end else if (fp == 3'd1 && data_byte == CH_DOT) begin
              field_position_next = 3'd2;
            end else if (fp == 3'd2 && (data_byte == CH_ZERO || data_byte == CH_ONE)) begin
              version_bit_next    = data_byte[0];
              field_position_next = 3'd3;
            end else if (fp == 3'd3 && data_byte == CH_SPACE) begin
              parse_phase_next    = PH_STATUS;
              field_position_next = 3'd0;
              code_value_next     = 10'd0;
            end else begin
              res_valid = 1'b1;
              err       = ERR_VERSION;
            end
          end
          PH_STATUS: begin
            if (fp < 3'd3) begin
              if (data_byte < CH_ZERO || data_byte > CH_NINE) begin
                res_valid = 1'b1;
                err       = ERR_STATUS_BAD;
              end else begin
                // code * 10 + digit; stays below 1000
                code_value_next     = (cv << 3) + (cv << 1) + {6'd0, data_byte[3:0]};
                field_position_next = fp + 3'd1;
              end
            end else if (data_byte != CH_SPACE) begin
              res_valid = 1'b1;
              err       = ERR_STATUS_BAD;
            end else if (!code_ok) begin
              res_valid   = 1'b1;
              err         = ERR_STATUS_UNK;
              show_status = 1'b1;
            end else begin
              parse_phase_next    = PH_REASON;
              field_position_next = 3'd0;
              pending_marks_next  = 2'd0;
            end
          end
          default: begin
            // reason phrase, header key or header value
            if ((pending_marks_next & PM_CR) != 2'd0) begin
              pending_marks_next = pending_marks_next & ~PM_CR;
              if (data_byte == CH_LF) begin
                handled = 1'b1;
                if (ph == PH_REASON) begin
                  parse_phase_next = PH_KEY;
                  line_flags_next  = 4'd0;
                end else if (ph == PH_KEY) begin
                  res_valid   = 1'b1;
                  show_status = 1'b1;
                  err         = (line_flags_next == 4'd0) ? ERR_OK : ERR_NO_SEP;
                end else if ((line_flags_next & LF_KEY_SEEN) == 4'd0) begin
                  res_valid   = 1'b1;
                  show_status = 1'b1;
                  err         = ERR_NO_NAME;
                end else if ((line_flags_next & LF_KEY_BAD) != 4'd0) begin
                  res_valid   = 1'b1;
                  show_status = 1'b1;
                  err         = ERR_BAD_CHAR;
                end else if ((line_flags_next & LF_VAL_SEEN) == 4'd0) begin
                  res_valid   = 1'b1;
                  show_status = 1'b1;
                  err         = ERR_NO_VALUE;
                end else if ((line_flags_next & LF_VAL_BAD) != 4'd0) begin
                  res_valid   = 1'b1;
                  show_status = 1'b1;
                  err         = ERR_BAD_CHAR;
                end else begin
                  if (hs != HEADERS_SAT) begin
                    headers_seen_next = hs + 10'd1;
                  end
                  line_flags_next  = 4'd0;
                  parse_phase_next = PH_KEY;
                end
              end else if (ph == PH_KEY) begin
                // bare CR is a bad key character
                line_flags_next = line_flags_next | LF_KEY_SEEN | LF_KEY_BAD;
              end else if (ph == PH_VALUE) begin
                line_flags_next = line_flags_next | LF_VAL_SEEN | LF_VAL_BAD;
              end
            end
            if (!handled) begin
              if (data_byte == CH_CR) begin
                if (ph == PH_KEY && (pending_marks_next & PM_COLON) != 2'd0) begin
                  pending_marks_next = pending_marks_next & ~PM_COLON;
                  line_flags_next    = line_flags_next | LF_KEY_SEEN | LF_KEY_BAD;
                end
                pending_marks_next = pending_marks_next | PM_CR;
              end else if (ph != PH_REASON) begin
                if (ph == PH_KEY) begin
                  if ((pending_marks_next & PM_COLON) != 2'd0) begin
                    pending_marks_next = pending_marks_next & ~PM_COLON;
                    if (data_byte == CH_SPACE) begin
                      parse_phase_next = PH_VALUE;
                      skip             = 1'b1;
                    end else begin
                      // lone colon counts as a bad key character
                      line_flags_next = line_flags_next | LF_KEY_SEEN | LF_KEY_BAD;
                    end
                  end
                  if (!skip && data_byte == CH_COLON) begin
                    pending_marks_next = pending_marks_next | PM_COLON;
                    skip               = 1'b1;
                  end
                end
                if (!skip) begin
                  if (ph == PH_KEY) begin
                    line_flags_next = line_flags_next | LF_KEY_SEEN |
                                      (cls.name_safe ? 4'd0 : LF_KEY_BAD);
                  end else if (ph == PH_VALUE) begin
                    line_flags_next = line_flags_next | LF_VAL_SEEN |
                                      (cls.value_safe ? 4'd0 : LF_VAL_BAD);
                  end
                end
              end
            end
          end
        endcase
      end
      if (res_valid) begin
        finished_next = 1'b1;
      end
    end

    result.error_code    = err;
    result.version_minor = (ph >= PH_STATUS) ? vb : 1'b0;
    result.resp_code     = (show_status || ph >= PH_REASON) ? cv : 10'd0;
    result.header_count  = hs;
    result.header_bytes  = byte_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_SEEK;
      finished       <= 1'b0;
      byte_count     <= 16'd0;
      field_position <= 3'd0;
      version_bit    <= 1'b0;
      code_value     <= 10'd0;
      line_flags     <= 4'd0;
      pending_marks  <= 2'd0;
      crlf_run       <= 2'd0;
      headers_seen   <= 10'd0;
    end else if (step) begin
      parse_phase    <= parse_phase_next;
      finished       <= finished_next;
      byte_count     <= byte_count_next;
      field_position <= field_position_next;
      version_bit    <= version_bit_next;
      code_value     <= code_value_next;
      line_flags     <= line_flags_next;
      pending_marks  <= pending_marks_next;
      crlf_run       <= crlf_run_next;
      headers_seen   <= headers_seen_next;
    end
  end

endmodule

/* tb/http_response_header_checker_test.sv */
// Self-checking testbench for the HTTP response header checker.
module http_response_header_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hrhc_pkg::*;

  // Result gap after the last accepted word: two register stages plus margin.
  localparam int SETTLE_CYCLES = 8;
  localparam int NO_VERDICT    = -1;
  localparam int CODE_COUNT    = 62;
  localparam int SYMBOL_COUNT  = 33;

  typedef struct packed {
    logic [7:0] value;
    logic       fresh;
  } rx_word_t;

  // DUT-facing signals
  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        first_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  error_code;
  logic        version_minor;
  logic [9:0]  resp_code;
  logic [9:0]  header_count;
  logic [15:0] header_bytes;

  // Stimulus and scoreboard storage
  rx_word_t     pending_words[$];
  logic [7:0]   draft[$];
  hrhc_result_t expected_verdicts[$];
  hrhc_result_t got_word;
  hrhc_result_t want_word;
  rx_word_t     next_word;
  bit           word_taken = 1'b0;

  int send_idle_pct;
  int recv_idle_pct;
  int fail_count;
  int reports_made;
  int words_checked;
  int bytes_queued;
  int responses_queued;
  bit [8:0] codes_seen;

  // Shadow parse state for the header predictor
  logic [3:0]  scan_state;
  bit          verdict_given;
  logic [15:0] taken_bytes;
  int          field_idx;
  bit          minor_ver;
  logic [9:0]  status_acc;
  bit          key_any, key_bad, val_any, val_bad;
  bit          held_cr, held_colon;
  logic [1:0]  blank_run;
  logic [9:0]  lines_ok;
  logic [15:0] byte_limit;

  http_response_header_checker u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .error_code   (error_code),
    .version_minor(version_minor),
    .resp_code    (resp_code),
    .header_count (header_count),
    .header_bytes (header_bytes)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Character classes and the status table
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] alnum_at(int r);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 36) return 8'(8'h61 + (r - 10));
    return 8'(8'h41 + (r - 36));
  endfunction

  // Punctuation allowed in a header value, space included
  function automatic logic [7:0] symbol_at(int i);
    case (i)
      0: return 8'h5F;  1: return 8'h20;  2: return 8'h3A;  3: return 8'h3B;
      4: return 8'h2E;  5: return 8'h2C;  6: return 8'h5C;  7: return 8'h2F;
      8: return 8'h22;  9: return 8'h27; 10: return 8'h3F; 11: return 8'h21;
     12: return 8'h28; 13: return 8'h29; 14: return 8'h7B; 15: return 8'h7D;
     16: return 8'h5B; 17: return 8'h5D; 18: return 8'h40; 19: return 8'h3C;
     20: return 8'h3E; 21: return 8'h3D; 22: return 8'h2D; 23: return 8'h2B;
     24: return 8'h2A; 25: return 8'h23; 26: return 8'h24; 27: return 8'h26;
     28: return 8'h60; 29: return 8'h7C; 30: return 8'h7E; 31: return 8'h5E;
      default: return 8'h25;
    endcase
  endfunction

  // Known status codes, in ascending order
  function automatic logic [9:0] listed_code(int i);
    if (i < 4)   return 10'(10'd100 + i);
    if (i < 13)  return 10'(10'd200 + (i - 4));
    if (i == 13) return 10'd226;
    if (i < 20)  return 10'(10'd300 + (i - 14));
    if (i == 20) return 10'd307;
    if (i == 21) return 10'd308;
    if (i < 41)  return 10'(10'd400 + (i - 22));
    if (i < 47)  return 10'(10'd421 + (i - 41));
    if (i == 47) return 10'd428;
    if (i == 48) return 10'd429;
    if (i == 49) return 10'd431;
    if (i == 50) return 10'd451;
    if (i < 60)  return 10'(10'd500 + (i - 51));
    if (i == 60) return 10'd510;
    return 10'd511;
  endfunction

  function automatic bit status_listed(logic [9:0] code);
    for (int i = 0; i < CODE_COUNT; i++)
      if (listed_code(i) == code) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic bit key_char_ok(logic [7:0] c);
    return is_alnum(c) || c == 8'h2D || c == 8'h5F;
  endfunction

  function automatic bit value_char_ok(logic [7:0] c);
    if (is_alnum(c)) return 1'b1;
    for (int i = 0; i < SYMBOL_COUNT; i++)
      if (symbol_at(i) == c) return 1'b1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Header predictor
  // ---------------------------------------------------------------------------

  function automatic void restart_parse();
    scan_state    = PH_SEEK;
    verdict_given = 1'b0;
    taken_bytes   = '0;
    field_idx     = 0;
    minor_ver     = 1'b0;
    status_acc    = '0;
    {key_any, key_bad, val_any, val_bad} = '0;
    {held_cr, held_colon} = '0;
    blank_run     = '0;
    lines_ok      = '0;
  endfunction

  function automatic hrhc_result_t verdict(logic [3:0] err, bit show_code);
    hrhc_result_t r;
    r.error_code    = err;
    r.version_minor = (scan_state >= PH_STATUS) ? minor_ver : 1'b0;
    r.resp_code     = (show_code || scan_state >= PH_REASON) ? status_acc : '0;
    r.header_count  = lines_ok;
    r.header_bytes  = taken_bytes;
    verdict_given   = 1'b1;
    return r;
  endfunction

  // Only key and value text is judged; status line text is never looked at
  function automatic void note_char(logic [7:0] c);
    if (scan_state == PH_KEY) begin
      key_any = 1'b1;
      if (!key_char_ok(c)) key_bad = 1'b1;
    end else if (scan_state == PH_VALUE) begin
      val_any = 1'b1;
      if (!value_char_ok(c)) val_bad = 1'b1;
    end
  endfunction

  // Line judged at its CRLF: separator, empty key, bad key, empty value, bad value
  function automatic int close_line();
    if (scan_state == PH_REASON) begin
      scan_state = PH_KEY;
      {key_any, key_bad, val_any, val_bad} = '0;
      return NO_VERDICT;
    end
    if (scan_state == PH_KEY)
      return (key_any || key_bad || val_any || val_bad) ? int'(ERR_NO_SEP) : int'(ERR_OK);
    if (!key_any) return int'(ERR_NO_NAME);
    if (key_bad)  return int'(ERR_BAD_CHAR);
    if (!val_any) return int'(ERR_NO_VALUE);
    if (val_bad)  return int'(ERR_BAD_CHAR);
    if (lines_ok != HEADERS_SAT) lines_ok++;
    {key_any, key_bad, val_any, val_bad} = '0;
    scan_state = PH_KEY;
    return NO_VERDICT;
  endfunction

  function automatic int line_char(logic [7:0] b);
    if (held_cr) begin
      held_cr = 1'b0;
      if (b == CH_LF) return close_line();
      note_char(CH_CR);
    end
    if (b == CH_CR) begin
      if (scan_state == PH_KEY && held_colon) begin
        held_colon = 1'b0;
        note_char(CH_COLON);
      end
      held_cr = 1'b1;
      return NO_VERDICT;
    end
    if (scan_state == PH_REASON) return NO_VERDICT;
    if (scan_state == PH_KEY) begin
      if (held_colon) begin
        held_colon = 1'b0;
        if (b == CH_SPACE) begin
          scan_state = PH_VALUE;
          return NO_VERDICT;
        end
        note_char(CH_COLON);
      end
      if (b == CH_COLON) begin
        held_colon = 1'b1;
        return NO_VERDICT;
      end
    end
    note_char(b);
    return NO_VERDICT;
  endfunction

  // One accepted byte; returns 1 with the expected word when it ends the response
  function automatic bit parse_predict(logic [7:0] b, logic fresh, output hrhc_result_t res);
    int outcome;
    bit show_code;
    logic [7:0] wanted;
    outcome   = NO_VERDICT;
    show_code = 1'b0;
    res       = '0;
    if (fresh) restart_parse();
    if (verdict_given) return 1'b0;
    if (taken_bytes >= byte_limit) begin
      if (taken_bytes != BYTES_SAT) taken_bytes++;
      res = verdict(ERR_TOO_BIG, 1'b0);
      return 1'b1;
    end
    if (taken_bytes != BYTES_SAT) taken_bytes++;
    case (scan_state)
      PH_SEEK: begin
        if (b == CH_SLASH) begin
          scan_state = PH_VER;
          field_idx  = 0;
        end else begin
          // look for CR LF CR LF before any slash
          wanted = blank_run[0] ? CH_LF : CH_CR;
          if (b == wanted) begin
            if (blank_run == 2'd3) outcome = int'(ERR_VERSION);
            else blank_run++;
          end else begin
            blank_run = (b == CH_CR) ? 2'd1 : 2'd0;
          end
        end
      end
      PH_VER: begin
        if (field_idx == 0 && b == CH_ONE) field_idx = 1;
        else if (field_idx == 1 && b == CH_DOT) field_idx = 2;
        else if (field_idx == 2 && (b == CH_ZERO || b == CH_ONE)) begin
          minor_ver = (b == CH_ONE);
          field_idx = 3;
        end else if (field_idx == 3 && b == CH_SPACE) begin
          scan_state = PH_STATUS;
          field_idx  = 0;
          status_acc = '0;
        end else begin
          outcome = int'(ERR_VERSION);
        end
      end
      PH_STATUS: begin
        if (field_idx < 3) begin
          if (b < CH_ZERO || b > CH_NINE) outcome = int'(ERR_STATUS_BAD);
          else begin
            status_acc = 10'(status_acc * 10 + (b - CH_ZERO));
            field_idx++;
          end
        end else if (b != CH_SPACE) begin
          outcome = int'(ERR_STATUS_BAD);
        end else if (!status_listed(status_acc)) begin
          outcome   = int'(ERR_STATUS_UNK);
          show_code = 1'b1;
        end else begin
          scan_state = PH_REASON;
          field_idx  = 0;
          {held_cr, held_colon} = '0;
        end
      end
      default: begin
        if (scan_state > PH_VALUE) scan_state = PH_KEY;
        outcome = line_char(b);
        show_code = 1'b1;
      end
    endcase
    if (outcome == NO_VERDICT) return 1'b0;
    res = verdict(outcome[3:0], show_code);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued bytes at the falling edge, holds until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (!in_valid || word_taken) begin
      if (!rst && pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_word = pending_words.pop_front();
        in_valid   <= 1'b1;
        data_byte  <= next_word.value;
        first_byte <= next_word.fresh;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result words, then predicts from the byte taken this edge.
  // A byte's own result cannot show up on the edge that takes it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    word_taken = in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got_word = '{error_code, version_minor, resp_code, header_count, header_bytes};
        words_checked++;
        if (error_code <= ERR_TOO_BIG) codes_seen[error_code] = 1'b1;
        if (expected_verdicts.size() == 0) begin
          fail_count++;
          if (reports_made < 10) begin
            reports_made++;
            $display("unexpected result word: err=%0d ver=%0d code=%0d hdrs=%0d bytes=%0d",
                     got_word.error_code, got_word.version_minor, got_word.resp_code,
                     got_word.header_count, got_word.header_bytes);
          end
        end else begin
          want_word = expected_verdicts.pop_front();
          if (got_word !== want_word) begin
            fail_count++;
            if (reports_made < 10) begin
              reports_made++;
              $display("mismatch at %0t: expected err=%0d ver=%0d code=%0d hdrs=%0d bytes=%0d",
                       $realtime, want_word.error_code, want_word.version_minor,
                       want_word.resp_code, want_word.header_count, want_word.header_bytes);
              $display("                 got err=%0d ver=%0d code=%0d hdrs=%0d bytes=%0d",
                       got_word.error_code, got_word.version_minor, got_word.resp_code,
                       got_word.header_count, got_word.header_bytes);
            end
          end
        end
      end
      if (word_taken && parse_predict(data_byte, first_byte, want_word))
        expected_verdicts.push_back(want_word);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] key_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 62) return alnum_at(r);
    return (r == 62) ? 8'h2D : 8'h5F;
  endfunction

  function automatic logic [7:0] value_char();
    int r;
    r = $urandom_range(0, 61 + SYMBOL_COUNT);
    if (r < 62) return alnum_at(r);
    return symbol_at(r - 62);
  endfunction

  task automatic draft_text(string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endtask

  // Moves the draft into the send queue; the first byte (and an optional
  // second position) carries the new-response mark.
  task automatic commit_draft(int restart_at);
    rx_word_t w;
    for (int i = 0; i < draft.size(); i++) begin
      w.value = draft[i];
      w.fresh = (i == 0) || (i == restart_at);
      pending_words.push_back(w);
    end
    bytes_queued += draft.size();
    responses_queued++;
    draft.delete();
  endtask

  task automatic queue_directed(string s);
    draft_text(s);
    commit_draft(-1);
  endtask

  // Mostly well-formed responses with random content, some broken on purpose
  task automatic queue_random_response();
    int r, nh, fault, klen, vlen, len, pos, restart_at;
    logic [9:0] code;
    r = $urandom_range(0, 9);
    if (r == 1) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        pos = $urandom_range(0, 255);
        draft.push_back((pos == CH_SLASH) ? 8'h48 : pos[7:0]);
      end
    end else if (r > 1) begin
      draft_text("HTTP");
    end
    if ($urandom_range(0, 29) != 0) draft.push_back(CH_SLASH);
    draft_text("1.");
    draft.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
    draft.push_back(CH_SPACE);
    if ($urandom_range(0, 19) == 0)
      draft[draft.size() - 1 - $urandom_range(0, 3)] = 8'($urandom_range(0, 255));
    // status code: mostly listed, sometimes arbitrary digits or a stray byte
    r = $urandom_range(0, 19);
    if (r < 17) begin
      code = listed_code($urandom_range(0, CODE_COUNT - 1));
      draft.push_back(8'(CH_ZERO + code / 100));
      draft.push_back(8'(CH_ZERO + (code / 10) % 10));
      draft.push_back(8'(CH_ZERO + code % 10));
    end else begin
      for (int i = 0; i < 3; i++) draft.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      if (r == 19) draft[draft.size() - 1 - $urandom_range(0, 2)] = 8'($urandom_range(0, 255));
    end
    draft.push_back(CH_SPACE);
    len = $urandom_range(0, 6);
    for (int i = 0; i < len; i++) draft.push_back(value_char());
    if ($urandom_range(0, 11) == 0) draft.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
    draft.push_back(CH_CR);
    draft.push_back(CH_LF);
    // header lines, each with an occasional fault
    nh = $urandom_range(0, 3);
    for (int h = 0; h < nh; h++) begin
      fault = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 7)) : -1;
      klen  = (fault == 0) ? 0 : $urandom_range(1, 6);
      for (int i = 0; i < klen; i++) draft.push_back(key_char());
      if (fault == 1) draft.push_back(8'($urandom_range(0, 255)));
      if (fault == 2) begin
        draft.push_back(CH_COLON);
        draft.push_back(key_char());
      end
      if (fault == 6) draft.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
      if (fault != 7) draft.push_back(CH_COLON);
      if (fault != 3) draft.push_back(CH_SPACE);
      vlen = (fault == 4) ? 0 : $urandom_range(1, 8);
      for (int i = 0; i < vlen; i++) draft.push_back(value_char());
      if (fault == 5)
        draft.push_back(8'($urandom_range(0, 1) ? $urandom_range(128, 255)
                                                  : $urandom_range(0, 31)));
      draft.push_back(CH_CR);
      draft.push_back(CH_LF);
    end
    draft.push_back(CH_CR);
    draft.push_back(CH_LF);
    // whole-response noise: a flipped byte, a cut, trailing junk, a restart
    if ($urandom_range(0, 9) == 0)
      draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 14) == 0) begin
      len = $urandom_range(1, draft.size());
      while (draft.size() > len) void'(draft.pop_back());
    end
    if ($urandom_range(0, 7) == 0) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) draft.push_back(8'($urandom_range(0, 255)));
    end
    restart_at = ($urandom_range(0, 24) == 0) ? int'($urandom_range(1, draft.size())) : -1;
    commit_draft(restart_at);
  endtask

  task automatic queue_random_batch(int byte_goal, int resp_goal);
    int b0, r0;
    b0 = bytes_queued;
    r0 = responses_queued;
    while (bytes_queued - b0 < byte_goal || responses_queued - r0 < resp_goal)
      queue_random_response();
  endtask

  // Sender has nothing left, every expected word is in; then let the pipe empty
  task automatic settle();
    @(posedge clk);
    while (pending_words.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_byte_limit(logic [15:0] v);
    settle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    byte_limit   = v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    send_idle_pct = 10;
    recv_idle_pct = 62;
    fail_count    = 0;
    reports_made  = 0;
    words_checked = 0;
    bytes_queued  = 0;
    responses_queued = 0;
    codes_seen    = '0;
    byte_limit    = MAX_BYTES_RESET;
    restart_parse();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed responses at the reset limit
    queue_directed("HTTP/1.1 200 OK\015\012Content-Type: text/html\015\012X_id-9: a1\015\012\015\012");
    draft.push_back(8'h00);                      // NUL while hunting for the slash
    queue_directed("junk\015\012\015\012");      // never finds a slash
    queue_directed("/1.0 204 \015\012\015\012"); // status line only, no headers
    queue_directed("/1.2 200 ");
    draft_text("x: y\015\012");                  // ignored: response already finished
    commit_draft(-2);
    pending_words[pending_words.size() - 6].fresh = 1'b0;
    queue_directed("/1.1 2a0 ");
    queue_directed("/1.1 299 x");
    queue_directed("/1.1 200 \015\012ab\015\012");       // missing separator
    queue_directed("/1.1 200 \015\012: v\015\012");      // empty key
    queue_directed("/1.1 200 \015\012k:v: w\015\012");   // colon without space inside key
    queue_directed("/1.1 200 \015\012k: \015\012");      // empty value
    queue_directed("/1.1 200 \015\012k: v\377\015\012"); // top-bit byte in value
    queue_directed("/1.1 200 a\015b\012c\015\012k: a\015b\015\012"); // stray CR/LF
    queue_directed("/1.1 100 \015\012a\012: v\015\012"); // stray LF in key
    queue_directed("/1.1 200 \015\012k!: \015\012");     // bad key outranks empty value
    queue_directed("/1.1 511 Z\015\012A: ~%\015\012\015\012");

    // Smallest limit: nearly every response trips on its second byte
    set_byte_limit(16'd1);
    queue_random_batch(20, 2);

    // Sender light, receiver heavy; tight limit, with a full drain midway
    set_byte_limit(16'($urandom_range(24, 64)));
    queue_random_batch(150, 4);
    settle();
    queue_random_batch(150, 4);

    // Sender heavy, receiver light
    set_byte_limit(16'd300);
    send_idle_pct = 62;
    recv_idle_pct = 10;
    queue_random_batch(150, 4);
    set_byte_limit(MAX_BYTES_RESET);
    queue_random_batch(200, 5);

    // No idling, largest limit
    set_byte_limit(16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_batch(350, 8);

    settle();
    $display("Ran %0d bytes in %0d responses; %0d result words checked, %0d failures.",
             bytes_queued, responses_queued, words_checked, fail_count);
    $display("Error codes returned (bit per code, 8 down to 0): %b; limits from 1 to 65535.",
             codes_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("timeout: %0d bytes still queued, %0d results outstanding",
             pending_words.size(), expected_verdicts.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* http_response_header_checker.f */
rtl/core/hrhc_pkg.sv
rtl/core/hrhc_char_class.sv
rtl/core/hrhc_status_table.sv
rtl/core/hrhc_parser.sv
rtl/core/http_response_header_checker.sv
tb/http_response_header_checker_test.sv
